@@ hdl/nsc_pkg.sv @@
`default_nettype none

package nsc_pkg;

    localparam logic [7:0] ChDollar   = 8'h24;
    localparam logic [7:0] ChBang     = 8'h21;
    localparam logic [7:0] ChStar     = 8'h2A;
    localparam logic [7:0] ChComma    = 8'h2C;
    localparam logic [7:0] ChP        = 8'h50;
    localparam int         HeadDepth  = 6;
    localparam logic [2:0] HeadFull   = 3'(HeadDepth);
    localparam logic [2:0] HeadSat    = 3'd7;
    localparam logic [1:0] HexDigits  = 2'd2;

    // Phase of the sentence parser, one-hot.
    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_BODY  = 4'b0010,
        PH_SUM   = 4'b0100,
        PH_SKIP  = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_NO_STAR   = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_NO_COMMA  = 3'd4
    } t_status;

    typedef struct packed {
        t_phase                       phase;
        logic [7:0]                   running_xor;
        logic [7:0]                   received_sum;
        logic [1:0]                   hex_seen;
        logic                         hex_error;
        logic [HeadDepth-1:0][7:0]    head;
        logic [2:0]                   head_length;
        logic                         in_first;
        logic                         comma_found;
        logic                         encap;
        logic                         start_valid;
    } t_sent;

    typedef struct packed {
        t_status    status;
        logic       six_bit;
        logic       proprietary;
        logic [7:0] talker_a;
        logic [7:0] talker_b;
        logic [7:0] type_a;
        logic [7:0] type_b;
        logic [7:0] type_c;
        logic [7:0] computed_sum;
    } t_result;

    localparam t_sent SentClear = '{
        phase:        PH_START,
        running_xor:  8'd0,
        received_sum: 8'd0,
        hex_seen:     2'd0,
        hex_error:    1'b0,
        head:         '0,
        head_length:  3'd0,
        in_first:     1'b1,
        comma_found:  1'b0,
        encap:        1'b0,
        start_valid:  1'b0
    };

    // Returns {not_hex, nibble}.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else begin
            v = 5'b1_0000;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/nsc_track.sv @@
`default_nettype none

module nsc_track import nsc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic       i_ch,
    input  wire logic [7:0] i_byte,
    output t_sent           o_next
);

    t_sent r_sent;
    t_sent n_sent;
    logic [4:0] hexv;

    // i_ch carries the final-byte flag of the beat being taken.
    always_comb begin
        n_sent = r_sent;
        hexv   = hex_value(i_byte);
        unique case (r_sent.phase)
            PH_START: begin
                if (i_byte == ChDollar || i_byte == ChBang) begin
                    n_sent.start_valid = 1'b1;
                    n_sent.encap       = (i_byte == ChBang);
                    n_sent.phase       = PH_BODY;
                end else begin
                    n_sent.phase = PH_SKIP;
                end
            end
            PH_BODY: begin
                if (i_byte == ChStar) begin
                    n_sent.phase = PH_SUM;
                end else begin
                    n_sent.running_xor = r_sent.running_xor ^ i_byte;
                    if (i_byte == ChComma) begin
                        n_sent.comma_found = 1'b1;
                        n_sent.in_first    = 1'b0;
                    end else if (r_sent.in_first) begin
                        if (r_sent.head_length < HeadFull) begin
                            n_sent.head[r_sent.head_length] = i_byte;
                        end
                        if (r_sent.head_length != HeadSat) begin
                            n_sent.head_length = r_sent.head_length + 3'd1;
                        end
                    end
                end
            end
            PH_SUM: begin
                if (r_sent.hex_seen != HexDigits) begin
                    if (hexv[4]) begin
                        n_sent.hex_error = 1'b1;
                    end
                    n_sent.received_sum = {r_sent.received_sum[3:0],
                                           hexv[4] ? 4'd0 : hexv[3:0]};
                    n_sent.hex_seen = r_sent.hex_seen + 2'd1;
                end
            end
            PH_SKIP: begin
            end
            default: begin
                n_sent.phase = PH_SKIP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent <= SentClear;
        end else if (i_take) begin
            r_sent <= i_ch ? SentClear : n_sent;
        end
    end

    assign o_next = n_sent;

endmodule

`default_nettype wire

@@ hdl/nsc_format.sv @@
`default_nettype none

module nsc_format import nsc_pkg::*; (
    input  t_sent   i_sent,
    output t_result o_result
);

    logic       ok;
    logic       prop;
    logic [2:0] base;
    t_status    status;

    // A character beyond the length of the first field reads as zero.
    function automatic logic [7:0] head_at(input t_sent s, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'd0;
        if (pos < HeadFull && pos < s.head_length) begin
            c = s.head[pos];
        end
        return c;
    endfunction

    always_comb begin
        if (!i_sent.start_valid) begin
            status = ST_BAD_START;
        end else if (i_sent.phase != PH_SUM) begin
            status = ST_NO_STAR;
        end else if (i_sent.hex_error || i_sent.hex_seen != HexDigits ||
                     i_sent.received_sum != i_sent.running_xor) begin
            status = ST_BAD_SUM;
        end else if (!i_sent.comma_found) begin
            status = ST_NO_COMMA;
        end else begin
            status = ST_OK;
        end
    end

    assign ok   = (status == ST_OK);
    assign prop = ok && head_at(i_sent, 3'd0) == ChP && i_sent.head_length == HeadFull;
    assign base = {2'b00, prop};

    always_comb begin
        o_result              = '0;
        o_result.status       = status;
        o_result.six_bit      = i_sent.start_valid & i_sent.encap;
        o_result.computed_sum = i_sent.start_valid ? i_sent.running_xor : 8'd0;
        o_result.proprietary  = prop;
        if (ok) begin
            o_result.talker_a = head_at(i_sent, base);
            o_result.talker_b = head_at(i_sent, base + 3'd1);
            o_result.type_a   = head_at(i_sent, base + 3'd2);
            o_result.type_b   = head_at(i_sent, base + 3'd3);
            o_result.type_c   = head_at(i_sent, base + 3'd4);
        end
    end

endmodule

`default_nettype wire

@@ hdl/nsc_outbuf.sv @@
`default_nettype none

module nsc_outbuf import nsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_result   i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_result   o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid | i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (!out_free && i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

@@ hdl/nmea_sentence_checker.sv @@
// Channel | Direction | Handshake            | Beat contents
// input   | in        | i_valid / o_stall    | i_ch, i_last
// result  | out       | o_valid / i_stall    | o_status .. o_computed_sum
//
// One byte is taken per cycle while o_stall is low. Taking the final byte
// registers the result, in the skid stage if the output register stalls.
// Reset is synchronous and active low; it clears the parser and empties the
// output register and the skid stage.
// The input is stalled only while the skid stage holds a result, that is
// after the result side has stalled with a result already waiting.
`default_nettype none

module nmea_sentence_checker import nsc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_status,
    output logic            o_six_bit,
    output logic            o_proprietary,
    output logic [7:0]      o_talker_a,
    output logic [7:0]      o_talker_b,
    output logic [7:0]      o_type_a,
    output logic [7:0]      o_type_b,
    output logic [7:0]      o_type_c,
    output logic [7:0]      o_computed_sum
);

    logic    take;
    logic    full;
    t_sent   next_sent;
    t_result result;
    t_result out_data;

    // A beat is taken whenever the skid stage has room; the parser state
    // is the register in front of the single pass of logic.
    assign take    = i_valid && !full;
    assign o_stall = full;

    // The parser folds each byte into the sentence state and returns to its
    // cleared state after the final byte.
    nsc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_ch    (i_last),
        .i_byte  (i_ch),
        .o_next  (next_sent)
    );

    // The result is formed from the state as it stands after the final byte.
    nsc_format u_format (
        .i_sent   (next_sent),
        .o_result (result)
    );

    // Output register with a skid stage so that a stalled result does not
    // hold up the byte stream.
    nsc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && i_last),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_data)
    );

    assign o_status       = out_data.status;
    assign o_six_bit      = out_data.six_bit;
    assign o_proprietary  = out_data.proprietary;
    assign o_talker_a     = out_data.talker_a;
    assign o_talker_b     = out_data.talker_b;
    assign o_type_a       = out_data.type_a;
    assign o_type_b       = out_data.type_b;
    assign o_type_c       = out_data.type_c;
    assign o_computed_sum = out_data.computed_sum;

endmodule

`default_nettype wire

@@ hdl/nsc_checker.sv @@
`default_nettype none

module nsc_checker import nsc_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_status,
    input wire logic       o_six_bit,
    input wire logic       o_proprietary,
    input wire logic [7:0] o_talker_a,
    input wire logic [7:0] o_talker_b,
    input wire logic [7:0] o_type_a,
    input wire logic [7:0] o_type_b,
    input wire logic [7:0] o_type_c,
    input wire logic [7:0] o_computed_sum
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall present after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_computed_sum))
        else $error("stalled result changed");

    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> !o_proprietary && o_talker_a == 8'd0 &&
            o_talker_b == 8'd0 && o_type_a == 8'd0 && o_type_b == 8'd0 &&
            o_type_c == 8'd0)
        else $error("header fields set on a failed sentence");

    a_bad_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_BAD_START |-> !o_six_bit && o_computed_sum == 8'd0)
        else $error("bad start reports start details");

    a_prop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_proprietary |-> o_status == ST_OK)
        else $error("proprietary flag set on a failed sentence");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (.*);

`default_nettype wire
